// File: rtl/brf_pkg.sv
// Shared types and constants of the binary rectangle finder.
// No dependencies; the front end, back end, top and testbench import this package.
package brf_pkg;

  localparam int MaxCols   = 64;  // default column capacity
  localparam int MaxRows   = 64;  // largest usable frame height
  localparam int MaxRects  = 33;  // rectangle records kept for one pixel
  localparam int CoordW    = 6;   // width of every reported coordinate
  localparam int SizeW     = 7;   // width of the size registers
  localparam int CfgIdxW   = 1;
  localparam int CfgReset  = 64;
  localparam int OpqDepth  = 4;
  localparam int ResqDepth = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCols = 1'b0,
    CfgRows = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BkOps,
    BkFlush,
    BkMark
  } back_state_e;

  // One classified pixel, front to back.
  typedef struct packed {
    logic              px;
    logic              corner;
    logic              run_end;
    logic              last;       // last pixel of the frame
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] top;        // current row
    logic [CoordW-1:0] close_bot;  // row above, zero on the first row
    logic [CoordW-1:0] run_col;
    logic [CoordW-1:0] run_right;
  } op_t;

  typedef struct packed {
    logic              is_rect;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] bottom;
    logic [CoordW-1:0] right;
    logic              last;
  } res_t;

endpackage

// File: rtl/brf_fifo.sv
// Small register FIFO with full/empty flags.
// Used for the op queue and the result queue; depends on nothing.
module brf_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("fifo count beyond depth");

endmodule

// File: rtl/brf_front.sv
// Front end: raster position, row-above and run tracking, pixel classification.
// Depends on brf_pkg; feeds the op queue.
module brf_front #(
  parameter int MAX_COLS = brf_pkg::MaxCols
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [brf_pkg::SizeW-1:0]  cols_i,
  input  logic [brf_pkg::SizeW-1:0]  rows_i,
  input  logic                       push,
  input  logic                       pixel_i,
  output logic                       full,
  input  logic                       opq_full_i,
  output logic                       op_push_o,
  output brf_pkg::op_t               op_o
);
  import brf_pkg::*;

  localparam int ColIdxW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [CoordW-1:0]   col_q, col_d, run_start_q, run_start_d;
  logic [SizeW-1:0]    row_q, row_d;
  logic                left_q, left_d, run_act_q, run_act_d;
  logic [MAX_COLS-1:0] prev_q, prev_d;

  logic [SizeW-1:0]    cols, rows, r, rows_m1, cols_m1;
  logic [CoordW-1:0]   c, right;
  logic                accept, last_col, last_row, up, lf, corner, run_end, frame_end;

  // clamp sizes: zero counts as one, capped at capacity
  always_comb begin
    if (cols_i == '0) begin
      cols = SizeW'(1);
    end else if (cols_i > SizeW'(MAX_COLS)) begin
      cols = SizeW'(MAX_COLS);
    end else begin
      cols = cols_i;
    end
    if (rows_i == '0) begin
      rows = SizeW'(1);
    end else if (rows_i > SizeW'(MaxRows)) begin
      rows = SizeW'(MaxRows);
    end else begin
      rows = rows_i;
    end
  end

  assign cols_m1  = cols - SizeW'(1);
  assign rows_m1  = rows - SizeW'(1);
  // position beyond a shrunk frame is taken as the last one
  assign c        = ({1'b0, col_q} >= cols) ? CoordW'(cols_m1) : col_q;
  assign r        = (row_q >= rows) ? rows_m1 : row_q;
  assign last_col = ({1'b0, c} == cols_m1);
  assign last_row = (r == rows_m1);
  assign frame_end = last_col && last_row;

  assign up     = (r == '0) ? 1'b0 : prev_q[c[ColIdxW-1:0]];
  assign lf     = (c == '0) ? 1'b0 : left_q;
  assign corner = pixel_i && !lf && !up;
  assign run_end = (run_act_q || corner) && (!pixel_i || last_col);
  assign right  = pixel_i ? c : ((c == '0) ? '0 : c - CoordW'(1));

  assign full      = opq_full_i;
  assign accept    = push && !full;
  assign op_push_o = accept;

  always_comb begin
    op_o.px        = pixel_i;
    op_o.corner    = corner;
    op_o.run_end   = run_end;
    op_o.last      = frame_end;
    op_o.col       = c;
    op_o.top       = r[CoordW-1:0];
    op_o.close_bot = (r == '0) ? '0 : CoordW'(r - SizeW'(1));
    op_o.run_col   = corner ? c : run_start_q;
    op_o.run_right = right;
  end

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    left_d      = left_q;
    run_act_d   = run_act_q;
    run_start_d = run_start_q;
    prev_d      = prev_q;
    if (accept) begin
      prev_d[c[ColIdxW-1:0]] = pixel_i;
      left_d = pixel_i;
      if (corner) begin
        run_start_d = c;
        run_act_d   = 1'b1;
      end
      if (run_end) begin
        run_act_d = 1'b0;
      end
      if (frame_end) begin
        col_d     = '0;
        row_d     = '0;
        left_d    = 1'b0;
        run_act_d = 1'b0;
      end else if (last_col) begin
        col_d = '0;
        row_d = r + SizeW'(1);
      end else begin
        col_d = c + CoordW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= 1'b0;
      run_act_q   <= 1'b0;
      run_start_q <= '0;
      prev_q      <= '0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      left_q      <= left_d;
      run_act_q   <= run_act_d;
      run_start_q <= run_start_d;
      prev_q      <= prev_d;
    end
  end

endmodule

// File: rtl/brf_back.sv
// Back end: open-rectangle store, close detection, end-of-frame column flush.
// Depends on brf_pkg; reads the op queue, writes the result queue.
module brf_back #(
  parameter int MAX_COLS = brf_pkg::MaxCols
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  brf_pkg::op_t  op_i,
  input  logic          op_empty_i,
  output logic          op_pop_o,
  output logic          res_push_o,
  output brf_pkg::res_t res_o,
  input  logic          res_full_i
);
  import brf_pkg::*;

  localparam int ColIdxW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CntW    = $clog2(MaxRects + 1);

  back_state_e         state_q, state_d;
  logic [MAX_COLS-1:0] flag_q, flag_d;
  logic [ColIdxW-1:0]  k_q, k_d, opc, runc, rd_addr;
  logic [CntW-1:0]     rects_q, rects_d;
  logic [CoordW-1:0]   fl_row_q, fl_row_d;

  // open-rectangle edges, written before any read
  logic [CoordW-1:0]   top_mem [MAX_COLS];
  logic [CoordW-1:0]   right_mem [MAX_COLS];
  logic [CoordW-1:0]   rd_top_q, rd_right_q;

  // emit stage
  logic                b_valid_q, b_valid_d, b_is_rect_q, b_last_q;
  logic [CoordW-1:0]   b_left_q, b_bottom_q;

  logic b_free, op_take, close, fl_hit, fl_load, fl_step, mark_load, load_b;

  assign opc    = op_i.col[ColIdxW-1:0];
  assign runc   = op_i.run_col[ColIdxW-1:0];
  assign b_free = !b_valid_q || !res_full_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BkOps: begin
        if (!op_empty_i && b_free && op_i.last) begin
          state_d = BkFlush;
        end
      end
      BkFlush: begin
        if (b_free && k_q == ColIdxW'(MAX_COLS - 1)) begin
          state_d = BkMark;
        end
      end
      BkMark: begin
        if (b_free) begin
          state_d = BkOps;
        end
      end
      default: state_d = BkOps;
    endcase
  end

  // control outputs
  always_comb begin
    op_take   = 1'b0;
    fl_step   = 1'b0;
    mark_load = 1'b0;
    rd_addr   = opc;
    case (state_q)
      BkOps:   op_take = !op_empty_i && b_free;
      BkFlush: begin
        fl_step = b_free;
        rd_addr = k_q;
      end
      BkMark:  mark_load = b_free;
      default: ;
    endcase
  end

  assign op_pop_o = op_take;
  assign close    = op_take && flag_q[opc] && !op_i.px;
  assign fl_hit   = flag_q[k_q];
  assign fl_load  = fl_step && fl_hit && (rects_q < CntW'(MaxRects));
  assign load_b   = close || fl_load || mark_load;

  always_comb begin
    flag_d   = flag_q;
    rects_d  = rects_q;
    k_d      = k_q;
    fl_row_d = fl_row_q;
    if (op_take) begin
      if (close || op_i.corner) begin
        flag_d[opc] = 1'b0;
      end
      if (op_i.run_end) begin
        flag_d[runc] = 1'b1;
      end
      if (op_i.last) begin
        rects_d  = close ? CntW'(1) : '0;
        k_d      = '0;
        fl_row_d = op_i.top;
      end
    end
    if (fl_step) begin
      flag_d[k_q] = 1'b0;  // dropped past the cap as well
      k_d = k_q + ColIdxW'(1);
    end
    if (fl_load) begin
      rects_d = rects_q + CntW'(1);
    end
  end

  assign b_valid_d  = load_b || (b_valid_q && res_full_i);
  assign res_push_o = b_valid_q && !res_full_i;

  always_comb begin
    res_o.is_rect = b_is_rect_q;
    res_o.top     = b_is_rect_q ? rd_top_q : '0;
    res_o.left    = b_left_q;
    res_o.bottom  = b_bottom_q;
    res_o.right   = b_is_rect_q ? rd_right_q : '0;
    res_o.last    = b_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BkOps;
      flag_q    <= '0;
      rects_q   <= '0;
      k_q       <= '0;
      b_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      flag_q    <= flag_d;
      rects_q   <= rects_d;
      k_q       <= k_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fl_row_q <= fl_row_d;
    if (load_b) begin
      b_is_rect_q <= !mark_load;
      b_last_q    <= mark_load || (close && !op_i.last);
      if (close) begin
        b_left_q   <= op_i.col;
        b_bottom_q <= op_i.close_bot;
      end else if (fl_load) begin
        b_left_q   <= CoordW'(k_q);
        b_bottom_q <= fl_row_q;
      end else begin
        b_left_q   <= '0;
        b_bottom_q <= '0;
      end
    end
  end

  // store: read old contents before this cycle's writes
  always_ff @(posedge clk_i) begin
    if (load_b) begin
      rd_top_q   <= top_mem[rd_addr];
      rd_right_q <= right_mem[rd_addr];
    end
    if (op_take && op_i.corner) begin
      top_mem[opc] <= op_i.top;
    end
    if (op_take && op_i.run_end) begin
      right_mem[runc] <= op_i.run_right;
    end
  end

  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && res_full_i |=> b_valid_q && $stable(b_left_q) && $stable(b_bottom_q))
    else $error("pending result changed while stalled");

  a_no_op_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != BkOps |-> !op_pop_o)
    else $error("op taken during flush");

  a_rect_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rects_q <= CntW'(MaxRects))
    else $error("rectangle cap exceeded");

  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_load |=> b_valid_q && !b_is_rect_q && b_last_q)
    else $error("marker not flagged as last");

endmodule

// File: rtl/binary_rectangle_finder_unit.sv
// Binary rectangle finder. Pixels of a binary image enter in raster order,
// one per cycle, through a queue-style port (push/full); each solid rectangle
// of ones leaves as one record (top, left, bottom, right) through a second
// queue-style port (empty/pop), in order of completion: a rectangle closes when
// a zero appears under its left column. At the last pixel of a frame every
// still-open rectangle is flushed in column order with bottom = last row, at
// most MaxRects records for that pixel, followed by an end-of-frame marker
// (is_rect = 0, edges zero); last_of_run marks the final record caused by a
// pixel. Throughput is one pixel per cycle except at end of frame: the back
// end then walks all MAX_COLS columns of its open-rectangle store, one column
// per cycle while the result queue has room, then emits the marker. The front
// end keeps accepting pixels of the next frame during that walk until the op
// queue between the two halves (OpqDepth entries) fills. Frame size is set by
// the cols (index 0) and rows (index 1) registers; write them only when the
// block is idle. A size of zero counts as one, larger sizes are capped at
// MAX_COLS columns and MaxRows rows. Results come out one per cycle at most.
module binary_rectangle_finder_unit #(
  parameter int MAX_COLS = brf_pkg::MaxCols
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // pixel input
  input  logic                        push,
  output logic                        full,
  input  logic                        pixel_i,
  // result output
  output logic                        empty,
  input  logic                        pop,
  output logic                        is_rect_o,
  output logic [brf_pkg::CoordW-1:0]  top_o,
  output logic [brf_pkg::CoordW-1:0]  left_o,
  output logic [brf_pkg::CoordW-1:0]  bottom_o,
  output logic [brf_pkg::CoordW-1:0]  right_o,
  output logic                        last_of_run_o,
  // register write port
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [brf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [brf_pkg::SizeW-1:0]   cfg_data_i
);
  import brf_pkg::*;

  logic [SizeW-1:0] cols_q, rows_q;

  op_t  fr_op, bk_op;
  res_t bk_res, out_res;
  logic fr_push, opq_full, opq_empty, bk_pop, res_push, resq_full;

  // configuration registers, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= SizeW'(CfgReset);
      rows_q <= SizeW'(CfgReset);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgCols: cols_q <= cfg_data_i;
        CfgRows: rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front end: classify each pixel
  brf_front #(
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cols_i     (cols_q),
    .rows_i     (rows_q),
    .push       (push),
    .pixel_i    (pixel_i),
    .full       (full),
    .opq_full_i (opq_full),
    .op_push_o  (fr_push),
    .op_o       (fr_op)
  );

  // decoupling queue between front and back
  brf_fifo #(
    .W     ($bits(op_t)),
    .DEPTH (OpqDepth)
  ) u_opq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .data_i  (fr_op),
    .full_o  (opq_full),
    .pop_i   (bk_pop),
    .data_o  (bk_op),
    .empty_o (opq_empty)
  );

  // back end: store updates, closes and frame-end flush
  brf_back #(
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (bk_op),
    .op_empty_i (opq_empty),
    .op_pop_o   (bk_pop),
    .res_push_o (res_push),
    .res_o      (bk_res),
    .res_full_i (resq_full)
  );

  // result queue; its head is what the user sees
  brf_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (ResqDepth)
  ) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (bk_res),
    .full_o  (resq_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign is_rect_o     = out_res.is_rect;
  assign top_o         = out_res.top;
  assign left_o        = out_res.left;
  assign bottom_o      = out_res.bottom;
  assign right_o       = out_res.right;
  assign last_of_run_o = out_res.last;

endmodule

// File: tb/binary_rectangle_finder_unit_test.sv
// Self-checking testbench for binary_rectangle_finder_unit: drives pixel frames,
// predicts the rectangle records and frame markers, and checks every result.
// Depends on brf_pkg and the binary_rectangle_finder_unit RTL only.
module binary_rectangle_finder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import brf_pkg::*;

  localparam int CycleLimit = 400000;  // hard stop for a hung run
  localparam int TailCycles = 100;     // extra idle time after a drain
  localparam int HoldCycles = 400;     // long receiver hold-off, fills the block

  logic clk_i;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic pixel_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic is_rect_o;
  logic [CoordW-1:0] top_o, left_o, bottom_o, right_o;
  logic last_of_run_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CfgCols;
  logic [SizeW-1:0] cfg_data_i = '0;

  binary_rectangle_finder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .pixel_i       (pixel_i),
    .empty         (empty),
    .pop           (pop),
    .is_rect_o     (is_rect_o),
    .top_o         (top_o),
    .left_o        (left_o),
    .bottom_o      (bottom_o),
    .right_o       (right_o),
    .last_of_run_o (last_of_run_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Pixels waiting to be offered, and records the scanner owes us.
  bit   pixel_feed[$];
  res_t rect_due[$];
  int   errors = 0;

  // Idle percentages per side; changed only while the block is drained.
  int send_idle_pct = 20;
  int take_idle_pct = 83;
  bit stall_ask = 1'b0;

  // Scanner state, mirrored.
  bit          prev_row_q[MaxCols];
  bit          open_q[MaxCols];
  bit [5:0]    top_q[MaxCols];
  bit [5:0]    right_q[MaxCols];
  int unsigned row_q = 0, col_q = 0, run_col_q = 0;
  bit          left_q = 1'b0, run_on_q = 1'b0;
  bit [6:0]    cols_reg = 7'(CfgReset), rows_reg = 7'(CfgReset);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report(string msg);
    errors++;
    $display("ERROR %0t: %s", $time, msg);
  endtask

  // Zero reads as one, oversize is capped.
  function automatic int unsigned fit_size(bit [6:0] v, int unsigned cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return 32'(v);
  endfunction

  // Append one pixel to the pending stream.
  function automatic void queue_px(bit px);
    pixel_feed = {pixel_feed, px};
  endfunction

  function automatic void add_due(bit is_rect, int unsigned t, int unsigned l,
                                  int unsigned b, int unsigned rgt);
    res_t rec;
    rec.is_rect = is_rect;
    rec.top     = t[5:0];
    rec.left    = l[5:0];
    rec.bottom  = b[5:0];
    rec.right   = rgt[5:0];
    rec.last    = 1'b0;
    rect_due = {rect_due, rec};
  endfunction

  // Advance the mirrored scanner by one pixel and queue what it reports.
  function automatic void track_pixel(bit px);
    int unsigned ncol, nrow, c, r, s, rgt;
    bit up, lf, end_col, end_row;
    int rects, base;
    res_t rec;
    ncol = fit_size(cols_reg, MaxCols);
    nrow = fit_size(rows_reg, MaxRows);
    // a shrunk frame pulls the position back onto its last column / row
    if (col_q >= ncol) col_q = ncol - 1;
    if (row_q >= nrow) row_q = nrow - 1;
    c = col_q;
    r = row_q;
    end_col = (c == ncol - 1);
    end_row = (r == nrow - 1);
    up = (r == 0) ? 1'b0 : prev_row_q[c];
    lf = (c == 0) ? 1'b0 : left_q;
    base = rect_due.size();
    rects = 0;

    // zero under an open left column closes that rectangle
    if (open_q[c] && !px) begin
      add_due(1'b1, top_q[c], c, (r == 0) ? 0 : r - 1, right_q[c]);
      rects++;
      open_q[c] = 1'b0;
    end
    // top-left corner; drops whatever was open in this column
    if (px && !lf && !up) begin
      run_on_q  = 1'b1;
      run_col_q = c;
      top_q[c]  = r[5:0];
      open_q[c] = 1'b0;
    end
    // end of the top-row run fixes the right edge
    if (run_on_q && (!px || end_col)) begin
      s = run_col_q % MaxCols;
      rgt = px ? c : ((c == 0) ? 0 : c - 1);
      right_q[s] = rgt[5:0];
      open_q[s]  = 1'b1;
      run_on_q   = 1'b0;
    end
    prev_row_q[c] = px;
    left_q = px;

    if (end_col && end_row) begin
      // frame end: flush in column order, excess records are lost
      for (int k = 0; k < MaxCols; k++) begin
        if (open_q[k]) begin
          if (rects < MaxRects) begin
            add_due(1'b1, top_q[k], k, r, right_q[k]);
            rects++;
          end
          open_q[k] = 1'b0;
        end
      end
      add_due(1'b0, 0, 0, 0, 0);
      row_q = 0;
      col_q = 0;
      run_on_q = 1'b0;
      left_q = 1'b0;
    end else if (end_col) begin
      col_q = 0;
      row_q = r + 1;
    end else begin
      col_q = c + 1;
    end

    if (rect_due.size() > base) begin
      rec = rect_due[rect_due.size() - 1];
      rec.last = 1'b1;
      rect_due[rect_due.size() - 1] = rec;
    end
  endfunction

  // Pixel driver: holds an offer until it is taken, idles at random otherwise.
  always @(posedge clk_i) begin : pixel_drive
    bit nxt_push, nxt_px;
    if (!rst_ni) begin
      push    <= 1'b0;
      pixel_i <= 1'b0;
    end else begin
      if (push && !full) begin
        track_pixel(pixel_i);
        pixel_feed.delete(0);
      end
      nxt_push = push && full;
      nxt_px   = pixel_i;
      if (!nxt_push && pixel_feed.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt_push = 1'b1;
        nxt_px   = pixel_feed[0];
      end
      push    <= nxt_push;
      pixel_i <= nxt_px;
    end
  end

  // Result monitor and receiver; counts out the one long hold-off itself.
  int hold_left = 0;
  bit hold_used = 1'b0;

  always @(posedge clk_i) begin : result_take
    res_t seen, want;
    bit nxt_pop;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        seen = {is_rect_o, top_o, left_o, bottom_o, right_o, last_of_run_o};
        if (rect_due.size() == 0) begin
          report($sformatf("unexpected result %p", seen));
        end else begin
          want = rect_due.pop_front();
          if (seen.is_rect !== want.is_rect || seen.top !== want.top ||
              seen.left !== want.left || seen.bottom !== want.bottom ||
              seen.right !== want.right || seen.last !== want.last)
            report($sformatf("got %p, want %p", seen, want));
        end
      end
      if (stall_ask && !hold_used) begin
        hold_left = HoldCycles;
        hold_used = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_pop = 1'b0;
      end else begin
        nxt_pop = ($urandom_range(99) >= take_idle_pct);
      end
      pop <= nxt_pop;
    end
  end

  int unsigned cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Register write request; the mirror takes the value at the accepting edge.
  task automatic write_reg(cfg_reg_e idx, bit [6:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgCols) cols_reg = val;
    else rows_reg = val;
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every pixel is in and every record out, the frame marker
  // included, then idle for the tail so the block is truly idle.
  task automatic drain();
    while (pixel_feed.size() != 0 || rect_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // n pixels, bit n-1 of pat first
  task automatic feed_bits(int n, bit [15:0] pat);
    for (int i = n - 1; i >= 0; i--) queue_px(pat[i]);
  endtask

  // Comb row: ones on even columns plus the extra set, from column 0 on.
  task automatic feed_comb(int n, bit [63:0] extra);
    for (int c = 0; c < n; c++) queue_px((c % 2 == 0) || extra[c]);
  endtask

  // One frame: separated random rectangles, or plain noise.
  task automatic build_frame(int unsigned nc, int unsigned nr, bit noisy);
    bit img[64][64];
    int unsigned h, w, t, l, density;
    bit clear;
    for (int r = 0; r < 64; r++)
      for (int c = 0; c < 64; c++) img[r][c] = 1'b0;
    if (noisy) begin
      density = $urandom_range(80, 20);
      for (int r = 0; r < nr; r++)
        for (int c = 0; c < nc; c++) img[r][c] = ($urandom_range(99) < density);
    end else begin
      repeat ($urandom_range(6, 1)) begin
        h = $urandom_range(nr, 1);
        w = $urandom_range(nc, 1);
        t = $urandom_range(nr - h, 0);
        l = $urandom_range(nc - w, 0);
        clear = 1'b1;
        // keep a one-pixel gap to every other rectangle
        for (int r = int'(t) - 1; r <= int'(t + h); r++)
          for (int c = int'(l) - 1; c <= int'(l + w); c++)
            if (r >= 0 && r < nr && c >= 0 && c < nc && img[r][c]) clear = 1'b0;
        if (clear)
          for (int r = t; r < t + h; r++)
            for (int c = l; c < l + w; c++) img[r][c] = 1'b1;
      end
    end
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++) queue_px(img[r][c]);
  endtask

  initial begin : stimulus
    int fed, nfr, pick;
    int unsigned nc, nr;
    bit [6:0] cv, rv;

    for (int k = 0; k < MaxCols; k++) begin
      prev_row_q[k] = 1'b0;
      open_q[k]     = 1'b0;
      top_q[k]      = '0;
      right_q[k]    = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed ---
    // reset size 64x64: run of two ones opens a rectangle at column 0
    feed_bits(3, 3'b110);
    drain();
    // shrink to 2 cols, rows zero: position folds onto the last pixel, flush
    write_reg(CfgCols, 7'd2);
    write_reg(CfgRows, 7'd0);
    feed_bits(1, 1'b0);
    drain();
    // 3x3, one row in, then rows=1: zero closes on the first row, then a
    // run that ends on the last column is flushed with the marker
    write_reg(CfgCols, 7'd3);
    write_reg(CfgRows, 7'd3);
    feed_bits(3, 3'b100);
    drain();
    write_reg(CfgRows, 7'd1);
    feed_bits(3, 3'b011);
    drain();
    // single column (zero register), two rows
    write_reg(CfgCols, 7'd0);
    write_reg(CfgRows, 7'd2);
    feed_bits(2, 2'b11);
    drain();
    // corner over an open column: open col 0, fold back onto it, corner again
    write_reg(CfgCols, 7'd4);
    feed_bits(2, 2'b10);
    drain();
    write_reg(CfgCols, 7'd1);
    feed_bits(2, 2'b10);
    drain();

    // --- overflow: 34 open rectangles at frame end, one record dropped ---
    // even columns of a comb give 32; two folds onto odd columns add two more
    write_reg(CfgCols, 7'd64);
    write_reg(CfgRows, 7'd127);
    feed_comb(64, '0);
    feed_comb(62, '0);
    drain();
    write_reg(CfgCols, 7'd62);
    feed_bits(1, 1'b1);
    feed_comb(58, '0);
    drain();
    write_reg(CfgCols, 7'd58);
    feed_bits(1, 1'b1);
    drain();
    write_reg(CfgCols, 7'd64);
    write_reg(CfgRows, 7'd4);
    feed_comb(64, (64'd1 << 57) | (64'd1 << 61));
    drain();

    // --- random frames, three idling regimes ---
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 20 : (mode == 1) ? 83 : 0;
      take_idle_pct = (mode == 0) ? 83 : (mode == 1) ? 20 : 0;
      fed = 0;
      if (mode == 2) begin
        // receiver holds off while tiny frames keep coming: block backs up
        write_reg(CfgCols, 7'd2);
        write_reg(CfgRows, 7'd2);
        stall_ask = 1'b1;
        repeat (10) build_frame(2, 2, $urandom_range(99) < 20);
        drain();
      end
      while (fed < 15) begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          nc = 64;
          nr = 1;
        end else if (pick < 10) begin
          nc = 1;
          nr = 64;
        end else begin
          nc = $urandom_range(8, 1);
          nr = $urandom_range(8, 1);
        end
        cv = 7'(nc);
        rv = 7'(nr);
        if (nc == 1 && $urandom_range(1)) cv = 7'd0;
        if (nr == 1 && $urandom_range(1)) rv = 7'd0;
        if (nc == 64 && $urandom_range(1)) cv = 7'($urandom_range(127, 65));
        if (nr == 64 && $urandom_range(1)) rv = 7'($urandom_range(127, 65));
        write_reg(CfgCols, cv);
        write_reg(CfgRows, rv);
        nfr = (nc * nr > 32) ? 1 : $urandom_range(3, 1);
        repeat (nfr) build_frame(nc, nr, $urandom_range(99) < 20);
        fed += nfr * nc * nr;
        drain();
      end
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
